[rtl/core/wrrcq_pkg.sv]
// Shared types, codes and default sizes for the weighted round-robin class queue.
// No dependencies; every other file of the block but wrrcq_ram uses it through scoped names.
`default_nettype none

package wrrcq_pkg;

    // Default sizes
    localparam int NUM_CLASSES_DEF = 4;
    localparam int FIFO_DEPTH_DEF  = 16;
    localparam int DATA_WIDTH_DEF  = 16;

    // Fixed field widths of the channels
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int WEIGHT_REGS = 4;
    localparam int WEIGHT_W    = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } wrrcq_state_t;

endpackage

`default_nettype wire

[rtl/core/wrrcq_if.sv]
// Valid/ready channel interfaces for request and result items of the class queue.
// Depends on wrrcq_pkg for the field widths.
`default_nettype none

interface wrrcq_req_if;
    logic                           valid;
    logic                           ready;
    logic [wrrcq_pkg::KIND_W-1:0]   kind;
    logic [wrrcq_pkg::VALUE_W-1:0]  push_value;
    logic [wrrcq_pkg::CLASS_W-1:0]  class_index;

    modport source (output valid, kind, push_value, class_index, input ready);
    modport sink   (input valid, kind, push_value, class_index, output ready);
endinterface

interface wrrcq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [wrrcq_pkg::VALUE_W-1:0]   out_value;
    logic [wrrcq_pkg::CLASS_W-1:0]   served_class;
    logic [wrrcq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, out_value, served_class, status, input ready);
    modport sink   (input valid, out_value, served_class, status, output ready);
endinterface

`default_nettype wire

[rtl/core/weighted_round_robin_class_queue.sv]
// Weighted round-robin class queue: one FIFO per class in a shared RAM, served by weight.
// Depends on wrrcq_pkg, wrrcq_if (channel interfaces) and wrrcq_ram.
//
// Usage:
//   req (sink) takes one item: kind push/pop/peek, push_value, class_index.
//   rsp (source) returns exactly one item per request: out_value, served_class, status.
//   APB port writes weight_class0..3 at byte addresses 0, 4, 8, 12 (pready always high).
//   Write weights only while no request is in flight.
// Timing:
//   A request is taken only in the idle state; req.ready drops for the whole operation.
//   Push: decode writes the RAM (unless full) and the result register; done then loads the output register.
//   Pop/peek: a sequencer checks one class per cycle against its count and remaining
//   credit (one compare unit on the selected class), then reads the FIFO RAM, whose
//   read data is registered. Between 0 and NUM_CLASSES classes can be skipped before
//   the read; an all-empty request skips the scan and read states.
// Stall: the result waits in the output register; the next request is accepted while
//   it waits, but its own result holds until the register frees up.
// Reset: all FIFOs empty, class 0 current with no credit used, all weights 1.
`default_nettype none

module weighted_round_robin_class_queue #(
    parameter int NUM_CLASSES = wrrcq_pkg::NUM_CLASSES_DEF,
    parameter int FIFO_DEPTH  = wrrcq_pkg::FIFO_DEPTH_DEF,
    parameter int DATA_WIDTH  = wrrcq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    wrrcq_req_if.sink                            req,
    wrrcq_rsp_if.source                          rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wrrcq_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wrrcq_pkg::PDATA_W-1:0]   pwdata,
    output logic      [wrrcq_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready
);

    localparam int CW        = $clog2(NUM_CLASSES);
    localparam int PW        = $clog2(FIFO_DEPTH);
    localparam int CNTW      = $clog2(FIFO_DEPTH + 1);
    localparam int SUMW      = PW + 1;
    localparam int AW        = CW + PW;
    localparam int RAM_DEPTH = NUM_CLASSES * (1 << PW);
    localparam int KW        = (DATA_WIDTH < wrrcq_pkg::VALUE_W) ? DATA_WIDTH
                                                                 : wrrcq_pkg::VALUE_W;
    localparam int NREG      = (NUM_CLASSES < wrrcq_pkg::WEIGHT_REGS) ? NUM_CLASSES
                                                                      : wrrcq_pkg::WEIGHT_REGS;
    localparam int WIW       = $clog2(NREG);
    localparam int WW        = wrrcq_pkg::WEIGHT_W;
    localparam int VW        = wrrcq_pkg::VALUE_W;

    wrrcq_pkg::wrrcq_state_t state_reg, state_next;

    logic [wrrcq_pkg::KIND_W-1:0]  kind_reg;
    logic [VW-1:0]                 val_reg;
    logic [wrrcq_pkg::CLASS_W-1:0] cls_reg;

    logic [CW-1:0]   cur_reg, cur_next;
    logic [WW-1:0]   served_reg, served_next;
    logic [PW-1:0]   head_reg   [NUM_CLASSES];
    logic [PW-1:0]   head_next  [NUM_CLASSES];
    logic [CNTW-1:0] count_reg  [NUM_CLASSES];
    logic [CNTW-1:0] count_next [NUM_CLASSES];
    logic [WW-1:0]   weight_reg  [NREG];
    logic [WW-1:0]   weight_next [NREG];

    logic [VW-1:0]                  res_value_reg, res_value_next;
    logic [wrrcq_pkg::CLASS_W-1:0]  res_class_reg, res_class_next;
    logic [wrrcq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                           out_valid_reg, out_valid_next;
    logic [VW-1:0]                  out_value_reg, out_value_next;
    logic [wrrcq_pkg::CLASS_W-1:0]  out_class_reg, out_class_next;
    logic [wrrcq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic                   req_accept;
    logic [CW-1:0]          sel_cls;
    logic [PW-1:0]          sel_head;
    logic [CNTW-1:0]        sel_count;
    logic [SUMW-1:0]        pos_sum;
    logic [PW-1:0]          pos;
    logic [NUM_CLASSES-1:0] nonempty;
    logic                   any_nonempty;
    logic                   cls_ok;
    logic [WW-1:0]          cur_weight;
    logic [CW-1:0]          cur_inc;
    logic [WW-1:0]          served_inc;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                         cfg_write;
    logic [1:0]                   cfg_index;

    function automatic logic [WW-1:0] eff_weight(input logic [WW-1:0] w);
        return (w == '0) ? WW'(1) : w;
    endfunction

    wrrcq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready  = (state_reg == wrrcq_pkg::ST_IDLE);
    assign req_accept = req.valid && req.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.served_class = out_class_reg;
    assign rsp.status       = out_status_reg;

    // APB: register index sits in paddr[3:2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        prdata = '0;
        if (int'(cfg_index) < NREG)
        begin
            prdata = wrrcq_pkg::PDATA_W'(weight_reg[cfg_index[WIW-1:0]]);
        end
    end

    // Shared class lookup: push target while decoding, current class otherwise
    assign sel_cls   = (state_reg == wrrcq_pkg::ST_DECODE) ? CW'(cls_reg) : cur_reg;
    assign sel_head  = head_reg[sel_cls];
    assign sel_count = count_reg[sel_cls];
    assign cls_ok    = int'(cls_reg) < NUM_CLASSES;

    assign pos_sum = SUMW'(sel_head) + SUMW'(sel_count);
    assign pos     = (pos_sum >= SUMW'(FIFO_DEPTH)) ? PW'(pos_sum - SUMW'(FIFO_DEPTH))
                                                    : PW'(pos_sum);

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            nonempty[c] = (count_reg[c] != '0);
        end
    end
    assign any_nonempty = |nonempty;

    always_comb
    begin
        cur_weight = WW'(1);
        if (int'(cur_reg) < NREG)
        begin
            cur_weight = eff_weight(weight_reg[cur_reg[WIW-1:0]]);
        end
    end

    assign cur_inc    = (int'(cur_reg) == NUM_CLASSES - 1) ? '0 : cur_reg + CW'(1);
    assign served_inc = served_reg + WW'(1);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        served_next     = served_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        weight_next     = weight_reg;
        res_value_next  = res_value_reg;
        res_class_next  = res_class_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_class_next  = out_class_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = {sel_cls, pos};
        ram_wdata       = DATA_WIDTH'(val_reg[KW-1:0]);
        ram_re          = 1'b0;
        ram_raddr       = {cur_reg, sel_head};

        if (cfg_write && (int'(cfg_index) < NREG))
        begin
            weight_next[cfg_index[WIW-1:0]] = pwdata[WW-1:0];
        end

        unique case (state_reg)
            wrrcq_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = wrrcq_pkg::ST_DECODE;
                end
            end

            wrrcq_pkg::ST_DECODE:
            begin
                res_value_next  = '0;
                res_class_next  = '0;
                res_status_next = wrrcq_pkg::STATUS_OK;
                state_next      = wrrcq_pkg::ST_DONE;
                priority if (kind_reg == wrrcq_pkg::KIND_PUSH)
                begin
                    if (!cls_ok || (sel_count == CNTW'(FIFO_DEPTH)))
                    begin
                        res_status_next = wrrcq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        count_next[sel_cls] = sel_count + CNTW'(1);
                    end
                end
                else if ((kind_reg == wrrcq_pkg::KIND_POP) ||
                         (kind_reg == wrrcq_pkg::KIND_PEEK))
                begin
                    if (!any_nonempty)
                    begin
                        res_status_next = wrrcq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = wrrcq_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    // unused kind: result of all zeros
                    state_next = wrrcq_pkg::ST_DONE;
                end
            end

            wrrcq_pkg::ST_SCAN:
            begin
                // serve the current class if it has items and credit, else advance
                if ((sel_count != '0) && (served_reg < cur_weight))
                begin
                    ram_re     = 1'b1;
                    state_next = wrrcq_pkg::ST_READ;
                end
                else
                begin
                    cur_next    = cur_inc;
                    served_next = '0;
                end
            end

            wrrcq_pkg::ST_READ:
            begin
                res_value_next  = VW'(ram_rdata[KW-1:0]);
                res_class_next  = wrrcq_pkg::CLASS_W'(cur_reg);
                res_status_next = wrrcq_pkg::STATUS_OK;
                state_next      = wrrcq_pkg::ST_DONE;
                if (kind_reg == wrrcq_pkg::KIND_POP)
                begin
                    head_next[cur_reg]  = (sel_head == PW'(FIFO_DEPTH - 1)) ? '0
                                                                            : sel_head + PW'(1);
                    count_next[cur_reg] = sel_count - CNTW'(1);
                    if (served_inc >= cur_weight)
                    begin
                        cur_next    = cur_inc;
                        served_next = '0;
                    end
                    else
                    begin
                        served_next = served_inc;
                    end
                end
            end

            wrrcq_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_class_next  = res_class_reg;
                    out_status_next = res_status_reg;
                    state_next      = wrrcq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wrrcq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrrcq_pkg::ST_IDLE;
            cur_reg       <= '0;
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            for (int r = 0; r < NREG; r++)
            begin
                weight_reg[r] <= wrrcq_pkg::WEIGHT_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            weight_reg    <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            kind_reg <= req.kind;
            val_reg  <= req.push_value;
            cls_reg  <= req.class_index;
        end
        res_value_reg  <= res_value_next;
        res_class_reg  <= res_class_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_class_reg  <= out_class_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

[rtl/core/wrrcq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wrrcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/wrrcq_chk.sv]
// Port-level checks for the weighted round-robin class queue, bound to its top level.
// Depends on wrrcq_pkg for field widths and status codes.
`default_nettype none

module wrrcq_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [wrrcq_pkg::VALUE_W-1:0]   rsp_out_value,
    input wire logic [wrrcq_pkg::CLASS_W-1:0]   rsp_served_class,
    input wire logic [wrrcq_pkg::STATUS_W-1:0]  rsp_status
);

    // one item at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an item is in flight");

    // no result can appear in the cycle right after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early after accept");

    // failed operations return zero value and class
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != wrrcq_pkg::STATUS_OK) |->
            (rsp_out_value == '0) && (rsp_served_class == '0))
        else $error("error result carries a value");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value) &&
            $stable(rsp_served_class) && $stable(rsp_status))
        else $error("stalled result changed");

endmodule

bind weighted_round_robin_class_queue wrrcq_chk u_wrrcq_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_out_value    (rsp.out_value),
    .rsp_served_class (rsp.served_class),
    .rsp_status       (rsp.status)
);

`default_nettype wire

[test/weighted_round_robin_class_queue_tb.sv]
// Testbench for weighted_round_robin_class_queue: directed and random push/pop/peek
// traffic checked against an in-bench predictor of the class FIFOs and the weighted scheduler.
// Depends on wrrcq_pkg, wrrcq_if and the block RTL.
`default_nettype none

module weighted_round_robin_class_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES      = wrrcq_pkg::NUM_CLASSES_DEF;
    localparam int DEPTH        = wrrcq_pkg::FIFO_DEPTH_DEF;
    localparam int KIND_W       = wrrcq_pkg::KIND_W;
    localparam int VALUE_W      = wrrcq_pkg::VALUE_W;
    localparam int CLASS_W      = wrrcq_pkg::CLASS_W;
    localparam int STATUS_W     = wrrcq_pkg::STATUS_W;
    localparam int WEIGHT_W     = wrrcq_pkg::WEIGHT_W;
    localparam int PADDR_W      = wrrcq_pkg::PADDR_W;
    localparam int PDATA_W      = wrrcq_pkg::PDATA_W;
    localparam int REG_STRIDE   = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [KIND_W-1:0]   KIND_NOP   = 2'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'd255;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 8'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 8'd0;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] push_value;
        logic [CLASS_W-1:0] class_index;
    } request_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  out_value;
        logic [CLASS_W-1:0]  served_class;
        logic [STATUS_W-1:0] status;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    wrrcq_req_if req_ch ();
    wrrcq_rsp_if rsp_ch ();

    weighted_round_robin_class_queue u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // Scheduler and FIFO state as the block should hold it
    logic [VALUE_W-1:0]  class_mem [CLASSES][DEPTH];
    int unsigned         class_head [CLASSES];
    int unsigned         class_fill [CLASSES];
    logic [WEIGHT_W-1:0] class_weight [CLASSES];
    int unsigned         turn_class;
    int unsigned         turn_served;

    reply_t      awaited_replies [$];
    int unsigned error_count = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_max     = 0;

    function automatic int unsigned credit_of(int unsigned c);
        return (class_weight[c] == WEIGHT_ZERO) ? 1 : int'(class_weight[c]);
    endfunction

    function automatic bit all_classes_empty();
        for (int c = 0; c < CLASSES; c++)
        begin
            if (class_fill[c] != 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Move the turn past empty classes and classes whose credit is spent
    function automatic void advance_turn();
        for (int i = 0; i <= CLASSES; i++)
        begin
            if (class_fill[turn_class] != 0 && turn_served < credit_of(turn_class))
            begin
                return;
            end
            turn_class  = (turn_class + 1) % CLASSES;
            turn_served = 0;
        end
    endfunction

    function automatic reply_t predict_reply(request_t r);
        reply_t      rep;
        int unsigned c;
        rep = '0;
        rep.status = wrrcq_pkg::STATUS_OK;
        if (r.kind == wrrcq_pkg::KIND_PUSH)
        begin
            c = r.class_index;
            if (c >= CLASSES || class_fill[c] >= DEPTH)
            begin
                rep.status = wrrcq_pkg::STATUS_FULL;
            end
            else
            begin
                class_mem[c][(class_head[c] + class_fill[c]) % DEPTH] = r.push_value;
                class_fill[c]++;
            end
        end
        else if (r.kind == wrrcq_pkg::KIND_POP || r.kind == wrrcq_pkg::KIND_PEEK)
        begin
            if (all_classes_empty())
            begin
                rep.status = wrrcq_pkg::STATUS_EMPTY;
            end
            else
            begin
                advance_turn();
                c = turn_class;
                rep.out_value    = class_mem[c][class_head[c]];
                rep.served_class = CLASS_W'(c);
                if (r.kind == wrrcq_pkg::KIND_POP)
                begin
                    class_head[c] = (class_head[c] + 1) % DEPTH;
                    class_fill[c]--;
                    turn_served++;
                    if (turn_served >= credit_of(c))
                    begin
                        turn_class  = (turn_class + 1) % CLASSES;
                        turn_served = 0;
                    end
                end
            end
        end
        return rep;
    endfunction

    function automatic request_t make_request(logic [KIND_W-1:0] kind,
                                              logic [VALUE_W-1:0] value,
                                              logic [CLASS_W-1:0] cls);
        request_t r;
        r.kind        = kind;
        r.push_value  = value;
        r.class_index = cls;
        return r;
    endfunction

    function automatic request_t random_request(int unsigned push_pct);
        int unsigned       roll;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            kind = KIND_NOP;
        end
        else if (roll < 3 + push_pct)
        begin
            kind = wrrcq_pkg::KIND_PUSH;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            kind = wrrcq_pkg::KIND_PEEK;
        end
        else
        begin
            kind = wrrcq_pkg::KIND_POP;
        end
        return make_request(kind, VALUE_W'($urandom), CLASS_W'($urandom));
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight(int unsigned lo, int unsigned hi);
        return WEIGHT_W'($urandom_range(lo, hi));
    endfunction

    // Send one item; valid stays high into the next item unless a gap is drawn
    task automatic send_request(request_t r);
        int unsigned gap;
        req_ch.kind        <= r.kind;
        req_ch.push_value  <= r.push_value;
        req_ch.class_index <= r.class_index;
        req_ch.valid       <= 1'b1;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        awaited_replies.push_back(predict_reply(r));
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0)
            begin
                gap = $urandom_range(0, gap_max);
            end
        end
        else
        begin
            burst_left--;
        end
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one weight, then read it back
    task automatic write_weight(int unsigned c, logic [WEIGHT_W-1:0] w);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(c * REG_STRIDE);
        pwdata  <= PDATA_W'(w);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(w))
        begin
            $error("weight_class%0d expected %0d actual %0d", c, w, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        class_weight[c] = w;
    endtask

    task automatic set_weights(logic [WEIGHT_W-1:0] w0, logic [WEIGHT_W-1:0] w1,
                               logic [WEIGHT_W-1:0] w2, logic [WEIGHT_W-1:0] w3);
        wait_idle();
        write_weight(0, w0);
        write_weight(1, w1);
        write_weight(2, w2);
        write_weight(3, w3);
    endtask

    task automatic test_empty_queues();
        send_request(make_request(wrrcq_pkg::KIND_POP, '0, '0));
        send_request(make_request(wrrcq_pkg::KIND_PEEK, '1, '1));
        send_request(make_request(KIND_NOP, '1, '1));
    endtask

    task automatic test_push_extremes();
        send_request(make_request(wrrcq_pkg::KIND_PUSH, 16'h0000, 2'd0));
        send_request(make_request(wrrcq_pkg::KIND_PUSH, 16'hFFFF, 2'd1));
        send_request(make_request(wrrcq_pkg::KIND_PUSH, 16'hAAAA, 2'd2));
        send_request(make_request(wrrcq_pkg::KIND_PUSH, 16'h5555, 2'd3));
        send_request(make_request(wrrcq_pkg::KIND_PEEK, '0, '0));
        send_request(make_request(wrrcq_pkg::KIND_POP, '0, '0));
        send_request(make_request(wrrcq_pkg::KIND_POP, '0, '0));
        send_request(make_request(wrrcq_pkg::KIND_PEEK, '0, '0));
    endtask

    task automatic test_full_queue();
        while (class_fill[3] < DEPTH)
        begin
            send_request(make_request(wrrcq_pkg::KIND_PUSH, VALUE_W'($urandom), 2'd3));
        end
        // one more than the FIFO holds
        send_request(make_request(wrrcq_pkg::KIND_PUSH, VALUE_W'($urandom), 2'd3));
    endtask

    task automatic test_credit_used_up();
        int unsigned c;
        for (int k = 0; k < CLASSES; k++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                if (class_fill[k] < DEPTH)
                begin
                    send_request(make_request(wrrcq_pkg::KIND_PUSH, VALUE_W'($urandom),
                                              CLASS_W'(k)));
                end
            end
        end
        wait_idle();
        c = turn_class;
        write_weight(c, WEIGHT_MAX);
        repeat (3) send_request(make_request(wrrcq_pkg::KIND_POP, '0, '0));
        wait_idle();
        // lower the weight below what this class already served; zero acts as one
        write_weight(c, WEIGHT_MIN);
        write_weight((c + 1) % CLASSES, WEIGHT_ZERO);
        send_request(make_request(wrrcq_pkg::KIND_PEEK, '0, '0));
        repeat (4) send_request(make_request(wrrcq_pkg::KIND_POP, '0, '0));
    endtask

    task automatic test_random_traffic();
        int unsigned push_pct;
        for (int phase = 0; phase < 5; phase++)
        begin
            unique case (phase)
                0:
                begin
                    set_weights(WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
                    gap_max = 3;
                end
                1:
                begin
                    set_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
                    gap_max = 0;
                end
                2:
                begin
                    set_weights(WEIGHT_ZERO, WEIGHT_MIN, WEIGHT_MAX, 8'd128);
                    gap_max = 6;
                end
                3:
                begin
                    set_weights(random_weight(1, 255), random_weight(1, 255),
                                random_weight(1, 255), random_weight(1, 255));
                    gap_max = 2;
                end
                default:
                begin
                    set_weights(random_weight(0, 6), random_weight(0, 6),
                                random_weight(0, 6), random_weight(0, 6));
                    gap_max = 4;
                end
            endcase
            for (int n = 0; n < 80; n++)
            begin
                // alternate push-heavy and pop-heavy stretches so queue fill rises and falls
                push_pct = ((n / 15) % 2 == 0) ? 70 : 30;
                if (phase == 2 && n == 45)
                begin
                    wait_idle();
                end
                send_request(random_request(push_pct));
            end
        end
    endtask

    // Receiver: back-pressure in a randomly redrawn mode: always ready, random, mostly stalled or a fixed pattern
    initial
    begin
        int unsigned stall_cycle;
        int unsigned stall_mode;
        stall_cycle = 0;
        stall_mode  = 0;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall_cycle++;
            if (stall_cycle % 40 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            unique case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((stall_cycle % 8) < 5);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply with none pending: out_value %h served_class %0d status %0d",
                       rsp_ch.out_value, rsp_ch.served_class, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp_ch.out_value !== want.out_value)
                begin
                    $error("out_value expected %h actual %h", want.out_value, rsp_ch.out_value);
                    error_count++;
                end
                if (rsp_ch.served_class !== want.served_class)
                begin
                    $error("served_class expected %0d actual %0d",
                           want.served_class, rsp_ch.served_class);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_NOP;
        req_ch.push_value  <= '0;
        req_ch.class_index <= '0;
        for (int c = 0; c < CLASSES; c++)
        begin
            class_head[c]   = 0;
            class_fill[c]   = 0;
            class_weight[c] = wrrcq_pkg::WEIGHT_RESET;
        end
        turn_class  = 0;
        turn_served = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queues();
        test_push_extremes();
        test_full_queue();
        test_credit_used_up();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/wrrcq_pkg.sv
rtl/core/wrrcq_if.sv
rtl/core/wrrcq_ram.sv
rtl/core/weighted_round_robin_class_queue.sv
rtl/core/wrrcq_chk.sv
test/weighted_round_robin_class_queue_tb.sv
